@@ rtl/core/tcfad_pkg.sv @@
// Package for the two-class queue with dequeue by class or oldest of any class.
// Holds the request and response word types, operation and status codes, and defaults.
// No dependencies.
package tcfad_pkg;

   localparam int ClassDepthDefault = 16;
   localparam int TagBitsDefault    = 16;
   localparam int TagFieldBits      = 16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] SEL_CLASS0 = 2'd0;
   localparam logic [1:0] SEL_CLASS1 = 2'd1;
   localparam logic [1:0] SEL_ANY    = 2'd2;

   localparam logic [1:0] ST_ENQUEUED  = 2'd0;
   localparam logic [1:0] ST_DEQUEUED  = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic                    opcode;
      logic                    item_class;
      logic [TagFieldBits-1:0] item_tag;
      logic [1:0]              dequeue_select;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [TagFieldBits-1:0] out_tag;
      logic                    out_class;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

@@ rtl/core/two_class_fifo_with_any_dequeue_top.sv @@
// Top level of the two-class queue with dequeue by class or oldest of any class.
// Instantiates two tcfad_class_fifo queues; depends on tcfad_pkg.
//
//   Channel   Direction  Ports                        Word
//   request   in         req_valid, req_ready, req_data   tcfad_pkg::req_type
//   response  out        rsp_valid, rsp_ready, rsp_data   tcfad_pkg::rsp_type
//
// One word per cycle while responses are taken: a word is registered on entry, handled
// from the input register against both queue heads, and its response registered.
// Reset clears the pointers and the arrival counter; the queue memories are not
// cleared. A stalled response holds the input register, which then blocks entry.
module two_class_fifo_with_any_dequeue_top #(
   parameter int CLASS_DEPTH = tcfad_pkg::ClassDepthDefault,
   parameter int TAG_BITS    = tcfad_pkg::TagBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcfad_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcfad_pkg::rsp_type rsp_data
);

   localparam int StoreTagBits = (TAG_BITS < tcfad_pkg::TagFieldBits) ?
                                 TAG_BITS : tcfad_pkg::TagFieldBits;
   localparam int StampBits    = $clog2(4 * CLASS_DEPTH);
   localparam int DiffBits     = StampBits + 1;
   localparam int DataBits     = StoreTagBits + StampBits;

   tcfad_pkg::req_type         in_ff;
   logic                       in_v_ff;
   logic                       in_v_in;
   tcfad_pkg::rsp_type         rsp_ff;
   tcfad_pkg::rsp_type         rsp_in;
   logic                       rsp_v_ff;
   logic                       rsp_v_in;
   logic [StampBits-1:0]       arrival_ff;
   logic [StampBits-1:0]       arrival_in;
   logic                       take;
   logic                       proc;
   logic                       push0;
   logic                       push1;
   logic                       pop0;
   logic                       pop1;
   logic [DataBits-1:0]        push_data;
   tcfad_pkg::fifo_status_type stat0;
   tcfad_pkg::fifo_status_type stat1;
   logic [DataBits-1:0]        head0;
   logic [DataBits-1:0]        head1;
   logic [DiffBits-1:0]        diff;
   logic [DiffBits-1:0]        fwd;
   logic                       class1_older;

   assign take      = req_valid && req_ready;
   assign proc      = in_v_ff && (!rsp_v_ff || rsp_ready);
   assign req_ready = !in_v_ff || proc;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;
   assign in_v_in   = take ? 1'b1 : (proc ? 1'b0 : in_v_ff);
   assign rsp_v_in  = proc ? 1'b1 : (rsp_ready ? 1'b0 : rsp_v_ff);
   assign push_data = {in_ff.item_tag[StoreTagBits-1:0], arrival_ff};

   // Class 1 head is older when the forward distance to the class 0 stamp is
   // nonzero and below half the stamp range.
   assign diff = {1'b0, head0[StampBits-1:0]} - {1'b0, head1[StampBits-1:0]};
   assign fwd  = diff[StampBits] ? diff + DiffBits'(4 * CLASS_DEPTH) : diff;
   assign class1_older = (fwd != '0) && (fwd < DiffBits'(2 * CLASS_DEPTH));

   always_comb begin
      push0  = 1'b0;
      push1  = 1'b0;
      pop0   = 1'b0;
      pop1   = 1'b0;
      rsp_in = '{status: tcfad_pkg::ST_NOT_FOUND, out_tag: '0, out_class: 1'b0};
      if (in_ff.opcode == tcfad_pkg::OP_ENQUEUE) begin
         if (in_ff.item_class ? stat1.full : stat0.full) begin
            rsp_in.status = tcfad_pkg::ST_FULL;
         end else begin
            push0         = proc && !in_ff.item_class;
            push1         = proc && in_ff.item_class;
            rsp_in.status = tcfad_pkg::ST_ENQUEUED;
         end
      end else begin
         unique case (in_ff.dequeue_select)
            tcfad_pkg::SEL_CLASS0: pop0 = !stat0.empty;
            tcfad_pkg::SEL_CLASS1: pop1 = !stat1.empty;
            tcfad_pkg::SEL_ANY: begin
               if (!stat0.empty && !stat1.empty) begin
                  pop1 = class1_older;
                  pop0 = !class1_older;
               end else begin
                  pop0 = !stat0.empty;
                  pop1 = !stat1.empty;
               end
            end
            default: begin
               pop0 = 1'b0;
               pop1 = 1'b0;
            end
         endcase
         if (pop0) begin
            rsp_in.status  = tcfad_pkg::ST_DEQUEUED;
            rsp_in.out_tag = tcfad_pkg::TagFieldBits'(head0[DataBits-1:StampBits]);
         end else if (pop1) begin
            rsp_in.status    = tcfad_pkg::ST_DEQUEUED;
            rsp_in.out_tag   = tcfad_pkg::TagFieldBits'(head1[DataBits-1:StampBits]);
            rsp_in.out_class = 1'b1;
         end
         pop0 = pop0 && proc;
         pop1 = pop1 && proc;
      end
   end

   assign arrival_in = (push0 || push1) ?
                       ((arrival_ff == StampBits'(4 * CLASS_DEPTH - 1)) ?
                        '0 : arrival_ff + StampBits'(1)) :
                       arrival_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff    <= 1'b0;
         rsp_v_ff   <= 1'b0;
         arrival_ff <= '0;
      end else begin
         in_v_ff    <= in_v_in;
         rsp_v_ff   <= rsp_v_in;
         arrival_ff <= arrival_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_data;
      end
      if (proc) begin
         rsp_ff <= rsp_in;
      end
   end

   tcfad_class_fifo #(
      .DEPTH     (CLASS_DEPTH),
      .DATA_BITS (DataBits)
   ) u_class0 (
      .clock       (clock),
      .reset       (reset),
      .push        (push0),
      .push_data   (push_data),
      .pop         (pop0),
      .fifo_status (stat0),
      .head_data   (head0)
   );

   tcfad_class_fifo #(
      .DEPTH     (CLASS_DEPTH),
      .DATA_BITS (DataBits)
   ) u_class1 (
      .clock       (clock),
      .reset       (reset),
      .push        (push1),
      .push_data   (push_data),
      .pop         (pop1),
      .fifo_status (stat1),
      .head_data   (head1)
   );

endmodule

@@ rtl/core/tcfad_class_fifo.sv @@
// One class queue: a memory of tag and stamp entries with read and write pointers.
// The head entry is kept in a register read from the memory each cycle.
// Depends on tcfad_pkg.
module tcfad_class_fifo #(
   parameter int DEPTH     = tcfad_pkg::ClassDepthDefault,
   parameter int DATA_BITS = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [DATA_BITS-1:0]          push_data,
   input  logic                          pop,
   output tcfad_pkg::fifo_status_type    fifo_status,
   output logic [DATA_BITS-1:0]          head_data
);

   localparam int PtrBits = $clog2(2 * DEPTH);
   localparam int IdxBits = $clog2(DEPTH);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] head_ff;
   logic [PtrBits-1:0]   rd_ptr_ff;
   logic [PtrBits-1:0]   rd_ptr_in;
   logic [PtrBits-1:0]   wr_ptr_ff;
   logic [PtrBits-1:0]   wr_ptr_in;
   logic [IdxBits-1:0]   rd_idx;
   logic [IdxBits-1:0]   rd_idx_next;
   logic [IdxBits-1:0]   wr_idx;

   function automatic logic [IdxBits-1:0] ptr_index(input logic [PtrBits-1:0] p);
      logic [PtrBits-1:0] q;
      q = (p >= PtrBits'(DEPTH)) ? p - PtrBits'(DEPTH) : p;
      return q[IdxBits-1:0];
   endfunction

   function automatic logic [PtrBits-1:0] ptr_next(input logic [PtrBits-1:0] p);
      return (p == PtrBits'(2 * DEPTH - 1)) ? '0 : p + PtrBits'(1);
   endfunction

   assign rd_idx      = ptr_index(rd_ptr_ff);
   assign wr_idx      = ptr_index(wr_ptr_ff);
   assign rd_ptr_in   = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
   assign wr_ptr_in   = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
   assign rd_idx_next = ptr_index(rd_ptr_in);

   assign fifo_status.empty = (rd_ptr_ff == wr_ptr_ff);
   assign fifo_status.full  = (rd_ptr_ff != wr_ptr_ff) && (rd_idx == wr_idx);
   assign head_data         = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // The head register follows the next read position; a word written to that
   // position in the same cycle is forwarded.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_idx] <= push_data;
      end
      if (push && (wr_idx == rd_idx_next)) begin
         head_ff <= push_data;
      end else begin
         head_ff <= mem[rd_idx_next];
      end
   end

endmodule

@@ verif/tcfad_tb_model_pkg.sv @@
// Checking model for the two-class queue: predicts each response word and compares it.
// Holds a per-class store with arrival stamps and a queue of responses still due.
// Depends on tcfad_pkg for the word types and codes.
package tcfad_tb_model_pkg;
   import tcfad_pkg::*;

   localparam int ClassDepth = ClassDepthDefault;
   localparam int PtrBits    = $clog2(2 * ClassDepth);
   localparam int StampBits  = PtrBits + 1;

   typedef struct {
      logic [TagFieldBits-1:0] tag;
      logic [StampBits-1:0]    stamp;
   } queue_slot_type;

   class dequeue_order_model;
      queue_slot_type        slots[2][ClassDepth];
      logic [PtrBits-1:0]    rd_ptr[2];
      logic [PtrBits-1:0]    wr_ptr[2];
      logic [StampBits-1:0]  arrival;
      rsp_type               due_responses[$];
      int                    mismatches;
      int                    responses_seen;

      function new();
         rd_ptr[0] = '0;
         rd_ptr[1] = '0;
         wr_ptr[0] = '0;
         wr_ptr[1] = '0;
         arrival = '0;
         mismatches = 0;
         responses_seen = 0;
      endfunction

      function int pending();
         return due_responses.size();
      endfunction

      function logic [PtrBits-2:0] slot_index(logic [PtrBits-1:0] p);
         return p[PtrBits-2:0];
      endfunction

      // A stamp is older when the other is reached from it going forward by less than half
      // the counter range.
      function bit stamp_older(logic [StampBits-1:0] a, logic [StampBits-1:0] b);
         logic [StampBits-1:0] fwd;
         fwd = b - a;
         return (fwd != 0) && (fwd < (1 << (StampBits - 1)));
      endfunction

      function void note_request(req_type w);
         rsp_type              want;
         int                   cls;
         int                   pick;
         bit                   has0;
         bit                   has1;
         logic [PtrBits-1:0]   fill;
         logic [StampBits-1:0] s0;
         logic [StampBits-1:0] s1;
         want = '0;
         want.status = ST_NOT_FOUND;
         pick = -1;
         if (w.opcode == OP_ENQUEUE) begin
            cls = w.item_class;
            fill = wr_ptr[cls] - rd_ptr[cls];
            if (fill == ClassDepth) begin
               want.status = ST_FULL;
            end else begin
               slots[cls][slot_index(wr_ptr[cls])].tag = w.item_tag;
               slots[cls][slot_index(wr_ptr[cls])].stamp = arrival;
               wr_ptr[cls] = wr_ptr[cls] + 1'b1;
               arrival = arrival + 1'b1;
               want.status = ST_ENQUEUED;
            end
         end else begin
            has0 = rd_ptr[0] != wr_ptr[0];
            has1 = rd_ptr[1] != wr_ptr[1];
            case (w.dequeue_select)
               SEL_CLASS0: if (has0) pick = 0;
               SEL_CLASS1: if (has1) pick = 1;
               SEL_ANY: begin
                  if (has0 && has1) begin
                     s0 = slots[0][slot_index(rd_ptr[0])].stamp;
                     s1 = slots[1][slot_index(rd_ptr[1])].stamp;
                     pick = stamp_older(s1, s0) ? 1 : 0;
                  end else if (has0) begin
                     pick = 0;
                  end else if (has1) begin
                     pick = 1;
                  end
               end
               default: pick = -1;
            endcase
            if (pick >= 0) begin
               want.status = ST_DEQUEUED;
               want.out_tag = slots[pick][slot_index(rd_ptr[pick])].tag;
               want.out_class = (pick == 1);
               rd_ptr[pick] = rd_ptr[pick] + 1'b1;
            end
         end
         due_responses.push_back(want);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         $display("mismatch in response %0d: %s got %0h, want %0h",
                  responses_seen, field, got, want);
         mismatches++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         responses_seen++;
         if (due_responses.size() == 0) begin
            report("word with none due, status", 32'(got.status), 32'(0));
            return;
         end
         want = due_responses.pop_front();
         if (got.status !== want.status) begin
            report("status", 32'(got.status), 32'(want.status));
         end
         if (got.out_tag !== want.out_tag) begin
            report("out_tag", 32'(got.out_tag), 32'(want.out_tag));
         end
         if (got.out_class !== want.out_class) begin
            report("out_class", 32'(got.out_class), 32'(want.out_class));
         end
      endtask
   endclass

endpackage

@@ verif/tb_two_class_fifo_with_any_dequeue_top.sv @@
// Testbench for two_class_fifo_with_any_dequeue_top: directed and random enqueue and
// dequeue words with random idling on both channels, checked by dequeue_order_model.
// Depends on tcfad_pkg and tcfad_tb_model_pkg.
module tb_two_class_fifo_with_any_dequeue_top;
   import tcfad_pkg::*;
   import tcfad_tb_model_pkg::*;

   localparam logic [1:0] SEL_UNUSED = 2'd3;
   localparam int ItemTarget  = 1350;
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 10;
   localparam int LongHold    = 80;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   dequeue_order_model model = new();
   int words_sent = 0;
   int cycle_count = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   two_class_fifo_with_any_dequeue_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("two_class_fifo_with_any_dequeue_top verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type make_word(logic op, logic cls, logic [15:0] tag,
                                         logic [1:0] sel);
      req_type w;
      w.opcode = op;
      w.item_class = cls;
      w.item_tag = tag;
      w.dequeue_select = sel;
      return w;
   endfunction

   task automatic send_word(req_type w, int gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = w;
      do @(posedge clock); while (!req_ready);
      model.note_request(w);
      words_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (model.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = pick_gap();
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LongHold;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         model.check_response(rsp_data);
      end
   end

   initial begin
      int          burst_no;
      int          burst_len;
      int          enq_pct;
      int          cls1_pct;
      int          i;
      req_type     w;
      logic [1:0]  sel;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(make_word(OP_DEQUEUE, 1'b1, 16'hFFFF, SEL_CLASS0), pick_gap());
      send_word(make_word(OP_DEQUEUE, 1'b0, 16'h0000, SEL_CLASS1), pick_gap());
      send_word(make_word(OP_DEQUEUE, 1'b1, 16'h1234, SEL_ANY), pick_gap());
      send_word(make_word(OP_DEQUEUE, 1'b0, 16'h0000, SEL_UNUSED), pick_gap());
      send_word(make_word(OP_ENQUEUE, 1'b0, 16'hFFFF, SEL_UNUSED), pick_gap());
      send_word(make_word(OP_ENQUEUE, 1'b1, 16'h0000, SEL_ANY), pick_gap());
      send_word(make_word(OP_DEQUEUE, 1'b1, 16'hFFFF, SEL_UNUSED), pick_gap());
      send_word(make_word(OP_DEQUEUE, 1'b0, 16'h0000, SEL_ANY), pick_gap());
      send_word(make_word(OP_ENQUEUE, 1'b0, 16'hA5A5, SEL_CLASS1), pick_gap());
      send_word(make_word(OP_DEQUEUE, 1'b0, 16'h0000, SEL_ANY), pick_gap());
      send_word(make_word(OP_DEQUEUE, 1'b1, 16'h5A5A, SEL_CLASS0), pick_gap());
      for (i = 0; i < 17; i++) begin
         send_word(make_word(OP_ENQUEUE, 1'b1, 16'(i * 16'h0F0F), SEL_CLASS0), pick_gap());
      end

      burst_no = 0;
      while (words_sent < ItemTarget) begin
         burst_len = $urandom_range(10, 60);
         enq_pct = 25 + 25 * $urandom_range(2);
         cls1_pct = 10 + 40 * $urandom_range(2);
         quiet = ($urandom_range(3) == 0);
         if (burst_no == 5) begin
            quiet = 1'b1;
            enq_pct = 75;
            hold_request = 1'b1;
         end
         if (burst_no == 12) wait_for_drain();
         repeat (burst_len) begin
            case ($urandom_range(19))
               0, 1, 2, 3, 4, 5: sel = SEL_CLASS0;
               6, 7, 8, 9, 10, 11: sel = SEL_CLASS1;
               19: sel = SEL_UNUSED;
               default: sel = SEL_ANY;
            endcase
            w = make_word(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                          ($urandom_range(99) < cls1_pct), 16'($urandom), sel);
            send_word(w, pick_gap());
         end
         burst_no++;
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (model.mismatches == 0) begin
         $display("two_class_fifo_with_any_dequeue_top verification clean");
      end else begin
         $display("two_class_fifo_with_any_dequeue_top verification failed");
      end
      $finish;
   end

endmodule
